// ----- design/crsr_pkg.sv -----
// Shared types, widths and arithmetic helpers of the Catmull-Rom stereo resampler.
// No dependencies; every other file of the block imports this package.
package crsr_pkg;

  localparam int SAMPLE_BITS     = 16;
  localparam int PHASE_FRAC_BITS = 16;
  localparam int PHASE_W         = PHASE_FRAC_BITS + 5;
  localparam int T_BITS          = 16;
  localparam int V_SHIFT         = T_BITS + 1;
  localparam int COEF_W          = SAMPLE_BITS + 5;
  localparam int ACC_W           = SAMPLE_BITS + 24;
  localparam int PROD_W          = ACC_W + T_BITS + 1;
  localparam int MAX_RUN         = 64;
  localparam int RUN_W           = $clog2(MAX_RUN);
  localparam int NUM_CH          = 2;
  localparam int DATA_W          = ((2 * SAMPLE_BITS + 7) / 8) * 8;
  localparam int APB_DATA_W      = 32;
  localparam int ADDR_W          = 3;
  localparam int REG_IDX_W       = ADDR_W - 2;

  localparam logic [REG_IDX_W-1:0] REG_PHASE_STEP = REG_IDX_W'(0);

  localparam logic [PHASE_W:0] PHASE_ONE = (PHASE_W + 1)'(1) << PHASE_FRAC_BITS;

  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) <<< T_BITS;
  localparam logic signed [ACC_W-1:0] SAT_HI = (ACC_W'(1) <<< (SAMPLE_BITS - 1)) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] SAT_LO = -(ACC_W'(1) <<< (SAMPLE_BITS - 1));

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;        // shift the accepted frame into the windows
    logic coef;        // form the Catmull-Rom coefficients
    logic phase_drop;  // no output this input: phase falls by one frame
    logic mul1;        // p1 = a0*t + a1*2^16
    logic mul2;        // p2 = floor(p1*t/2^16) + a2*2^16
    logic mul3;        // v  = floor(p2*t/2^16) + y1*2^17
    logic emit;        // round, saturate and load the output register
    logic last;        // emitted frame ends the run
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic phase_ge_one;  // phase at or above one frame
    logic sum_ge_one;    // phase plus step at or above one frame
    logic out_busy;      // output register holds a frame that is not taken now
  } status_t;

  // Phase fraction reduced to a Q0.16 interpolation position.
  function automatic logic [T_BITS-1:0] frac_to_q16(input logic [PHASE_W-1:0] ph);
    logic [PHASE_FRAC_BITS+T_BITS-1:0] w;
    w = {ph[PHASE_FRAC_BITS-1:0], T_BITS'(0)};
    return w[PHASE_FRAC_BITS+T_BITS-1 -: T_BITS];
  endfunction

  // Divide by 2^17 rounding half away from zero, then clamp to the sample range.
  function automatic sample_t round_sat(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] r;
    if (v >= 0) begin
      r = (v + ROUND_HALF) >>> V_SHIFT;
    end else begin
      r = -((-v + ROUND_HALF) >>> V_SHIFT);
    end
    if (r > SAT_HI) begin
      r = SAT_HI;
    end else if (r < SAT_LO) begin
      r = SAT_LO;
    end
    return r[SAMPLE_BITS-1:0];
  endfunction

endpackage

// ----- design/crsr_ctrl.sv -----
// Sequencer of the resampler: input acceptance, run length and evaluation steps.
// Depends on crsr_pkg for the command and status structs.
module crsr_ctrl import crsr_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_COEF = 3'd1;
  localparam logic [2:0] S_MUL1 = 3'd2;
  localparam logic [2:0] S_MUL2 = 3'd3;
  localparam logic [2:0] S_MUL3 = 3'd4;
  localparam logic [2:0] S_EMIT = 3'd5;

  logic [2:0]       state, state_next;
  logic [RUN_W-1:0] count, count_next;
  logic             run_end;

  assign run_end  = status.sum_ge_one || (count == RUN_W'(MAX_RUN - 1));
  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    count_next = count;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_COEF;
        end
      end
      S_COEF: begin
        cmd.coef = 1'b1;
        if (status.phase_ge_one) begin
          cmd.phase_drop = 1'b1;
          state_next     = S_IDLE;
        end else begin
          count_next = '0;
          state_next = S_MUL1;
        end
      end
      S_MUL1: begin
        cmd.mul1   = 1'b1;
        state_next = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2   = 1'b1;
        state_next = S_MUL3;
      end
      S_MUL3: begin
        cmd.mul3   = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (!status.out_busy) begin
          cmd.emit = 1'b1;
          cmd.last = run_end;
          if (run_end) begin
            state_next = S_IDLE;
          end else begin
            count_next = count + RUN_W'(1);
            state_next = S_MUL1;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

endmodule

// ----- design/crsr_datapath.sv -----
// Datapath of the resampler: windows, phase, step register, two Horner lanes and
// the output register. Depends on crsr_pkg for widths, structs and rounding.
module crsr_datapath import crsr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  output status_t            status,
  input  sample_t            in_left,
  input  sample_t            in_right,
  input  logic               step_we,
  input  logic [PHASE_W-1:0] step_wdata,
  output logic [PHASE_W-1:0] step_value,
  output logic               out_valid,
  input  logic               out_ready,
  output sample_t            out_left,
  output sample_t            out_right,
  output logic               out_last
);

  sample_t                   win [NUM_CH][4];
  logic signed [COEF_W-1:0]  a0 [NUM_CH];
  logic signed [COEF_W-1:0]  a1 [NUM_CH];
  logic signed [COEF_W-1:0]  a2 [NUM_CH];
  logic signed [ACC_W-1:0]   acc [NUM_CH];
  logic signed [ACC_W-1:0]   mop [NUM_CH];
  logic signed [PROD_W-1:0]  prod [NUM_CH];
  logic signed [COEF_W-1:0]  y [NUM_CH][4];
  sample_t                   in_s [NUM_CH];
  logic                      primed;
  logic [PHASE_W-1:0]        phase;
  logic [PHASE_W-1:0]        phase_step;
  logic [PHASE_W:0]          phase_sum;
  logic signed [T_BITS:0]    t_s;

  assign in_s[0]    = in_left;
  assign in_s[1]    = in_right;
  assign phase_sum  = {1'b0, phase} + {1'b0, phase_step};
  assign t_s        = {1'b0, frac_to_q16(phase)};
  assign step_value = phase_step;

  assign status.phase_ge_one = ({1'b0, phase} >= PHASE_ONE);
  assign status.sum_ge_one   = (phase_sum >= PHASE_ONE);
  assign status.out_busy     = out_valid && !out_ready;

  // One multiplier per lane, shared by the three Horner steps.
  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      for (int k = 0; k < 4; k++) begin
        y[ch][k] = COEF_W'(win[ch][k]);
      end
      mop[ch]  = cmd.mul1 ? ACC_W'(a0[ch]) : acc[ch];
      prod[ch] = mop[ch] * t_s;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      primed     <= 1'b0;
      phase      <= '0;
      phase_step <= PHASE_ONE[PHASE_W-1:0];
      out_valid  <= 1'b0;
      for (int ch = 0; ch < NUM_CH; ch++) begin
        for (int k = 0; k < 4; k++) begin
          win[ch][k] <= '0;
        end
      end
    end else begin
      if (step_we) begin
        phase_step <= step_wdata;
      end
      if (cmd.load) begin
        primed <= 1'b1;
        for (int ch = 0; ch < NUM_CH; ch++) begin
          for (int k = 0; k < 3; k++) begin
            win[ch][k] <= primed ? win[ch][k+1] : in_s[ch];
          end
          win[ch][3] <= in_s[ch];
        end
      end
      if (cmd.phase_drop) begin
        phase <= PHASE_W'({1'b0, phase} - PHASE_ONE);
      end else if (cmd.emit) begin
        if (!cmd.last) begin
          phase <= phase_sum[PHASE_W-1:0];
        end else if (status.sum_ge_one) begin
          phase <= PHASE_W'(phase_sum - PHASE_ONE);
        end else begin
          phase <= '0;
        end
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers, no reset.
  always_ff @(posedge clk) begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      if (cmd.coef) begin
        a0[ch] <= -y[ch][0] + (y[ch][1] <<< 1) + y[ch][1]
                  - (y[ch][2] <<< 1) - y[ch][2] + y[ch][3];
        a1[ch] <= (y[ch][0] <<< 1) - (y[ch][1] <<< 2) - y[ch][1]
                  + (y[ch][2] <<< 2) - y[ch][3];
        a2[ch] <= y[ch][2] - y[ch][0];
      end
      if (cmd.mul1) begin
        acc[ch] <= ACC_W'(prod[ch]) + (ACC_W'(a1[ch]) <<< T_BITS);
      end else if (cmd.mul2) begin
        acc[ch] <= ACC_W'(prod[ch] >>> T_BITS) + (ACC_W'(a2[ch]) <<< T_BITS);
      end else if (cmd.mul3) begin
        acc[ch] <= ACC_W'(prod[ch] >>> T_BITS) + (ACC_W'(y[ch][1]) <<< V_SHIFT);
      end
    end
    if (cmd.emit) begin
      out_left  <= round_sat(acc[0]);
      out_right <= round_sat(acc[1]);
      out_last  <= cmd.last;
    end
  end

endmodule

// ----- design/catmull_rom_stereo_resampler_top.sv -----
// Top level of the Catmull-Rom stereo resampler: stream ports, APB register port.
// Depends on crsr_pkg, crsr_ctrl and crsr_datapath.
//
//   Channel   Direction  Transaction moves
//   s_*       in         one stereo input frame (left, right)
//   m_*       out        one interpolated stereo frame, tlast on the last of a run
//   APB       in/out     write or read of the phase_step register at address 0
//
// An input transaction is accepted in one step and its coefficients are formed in
// the next. Each output frame then takes three Horner steps on
// the per-channel multiplier and one rounding step into the output register.
// An input that causes no output takes only the accept and coefficient steps.
// Reset clears windows and phase and sets phase_step to 1.0 (Q5.16).
// A stall on m_tready holds the evaluation at its rounding step; s_tready is
// high only while the sequencer waits for a new frame.
module catmull_rom_stereo_resampler_top import crsr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [DATA_W-1:0]     s_tdata,   // left_sample, right_sample
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [DATA_W-1:0]     m_tdata,   // left_out, right_out
  output logic                  m_tlast,   // last_of_run
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_W-1:0]     paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  cmd_t               cmd;
  status_t            status;
  sample_t            out_left;
  sample_t            out_right;
  logic [PHASE_W-1:0] step_value;
  logic               reg_hit;
  logic               step_we;

  // Register decode. Byte-lane bits of paddr are ignored.
  assign pready  = 1'b1;
  assign reg_hit = (paddr[ADDR_W-1:2] == REG_PHASE_STEP);
  assign step_we = psel && penable && pwrite && pready && reg_hit;
  assign prdata  = reg_hit ? APB_DATA_W'(step_value) : '0;

  assign m_tdata = DATA_W'({out_right, out_left});

  crsr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  crsr_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .in_left    (s_tdata[SAMPLE_BITS-1:0]),
    .in_right   (s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
    .step_we    (step_we),
    .step_wdata (pwdata[PHASE_W-1:0]),
    .step_value (step_value),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_left   (out_left),
    .out_right  (out_right),
    .out_last   (m_tlast)
  );

endmodule

// ----- design/crsr_checker.sv -----
// Port-level checks of the resampler top level and the bind that attaches them.
// Depends on crsr_pkg and catmull_rom_stereo_resampler_top.
module crsr_checker import crsr_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              s_tvalid,
  input logic              s_tready,
  input logic              m_tvalid,
  input logic              m_tready,
  input logic [DATA_W-1:0] m_tdata,
  input logic              m_tlast
);

  // Reset leaves the block empty and waiting for a frame.
  a_reset_empty: assert property (@(posedge clk) rst |=> (!m_tvalid && s_tready))
    else $error("block not idle after reset");

  // Coefficient forming follows every accepted frame, so input is closed next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted on consecutive cycles");

  // No output frame can appear directly after an input transaction.
  a_no_instant_output: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && !m_tvalid) |=> !m_tvalid)
    else $error("output frame appeared one cycle after input");

  // A stalled output frame holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
    else $error("stalled output frame changed");

endmodule

bind catmull_rom_stereo_resampler_top crsr_checker u_crsr_checker (.*);
